// ----- rtl/ors_pkg.sv -----
`timescale 1ns / 1ps

package ors_pkg;

    localparam int ROM_BITS = 64;
    localparam int POS_W    = 7;
    localparam int CRC_W    = 8;

    // position code that no bit position can equal
    localparam logic [POS_W-1:0] POS_NONE = 7'd127;
    // reflected crc-8 polynomial x^8+x^5+x^4+1
    localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

    localparam int IN_W  = 8;
    localparam int OUT_W = 72;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_PASS    = 2'd1,
        ACT_TRIPLET = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_CONTINUE = 3'd0,
        ST_FOUND    = 3'd1,
        ST_DONE     = 3'd2,
        ST_ERROR    = 3'd3,
        ST_READY    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] action;
        logic       presence;
        logic       first_bit;
        logic       complement_bit;
        logic       taken_direction;
        logic       link_error;
    } item_t;

    typedef struct packed {
        logic [ROM_BITS-1:0] rom_store;
        logic [POS_W-1:0]    last_discrepancy;
        logic [POS_W-1:0]    last_zero_branch;
        logic [POS_W-1:0]    bit_position;
        logic                enumeration_finished;
        logic                pass_active;
        logic [CRC_W-1:0]    running_crc;
    } search_state_t;

    typedef struct packed {
        logic                next_direction;
        logic [2:0]          status;
        logic [ROM_BITS-1:0] serial_number;
        logic                last_device;
    } result_t;

    // below the last discrepancy repeat the stored bit, at it take 1, above it take 0
    function automatic logic pick_dir(input logic [POS_W-1:0] pos,
                                      input logic [POS_W-1:0] ld,
                                      input logic [ROM_BITS-1:0] rom);
        logic d;
        d = 1'b0;
        if (ld != POS_NONE && pos < ld) begin
            d = rom[pos[5:0]];
        end else if (ld != POS_NONE && pos == ld) begin
            d = 1'b1;
        end
        return d;
    endfunction

endpackage

// ----- rtl/ors_step.sv -----
`timescale 1ns / 1ps

module ors_step (
    input  ors_pkg::item_t         item,
    input  ors_pkg::search_state_t cur,
    output ors_pkg::search_state_t nxt,
    output ors_pkg::result_t       res
);
    import ors_pkg::*;

    logic [ROM_BITS-1:0] rom_upd;
    logic [CRC_W-1:0]    crc_upd;
    logic [POS_W-1:0]    pos_upd;
    logic [POS_W-1:0]    lzb_upd;
    logic                fb;

    // one search step on the taken direction
    always_comb begin
        fb      = cur.running_crc[0] ^ item.taken_direction;
        crc_upd = (cur.running_crc >> 1) ^ (fb ? CRC_POLY : '0);
        rom_upd = cur.rom_store;
        rom_upd[cur.bit_position[5:0]] = item.taken_direction;
        pos_upd = cur.bit_position + 1'b1;
        lzb_upd = (!item.first_bit && !item.complement_bit && !item.taken_direction)
                  ? cur.bit_position : cur.last_zero_branch;
    end

    // next state and result per action
    always_comb begin
        logic    dir;
        status_t st;
        nxt = cur;
        dir = 1'b0;
        st  = ST_ERROR;
        unique case (item.action)
            ACT_START: begin
                nxt.last_discrepancy     = POS_NONE;
                nxt.enumeration_finished = 1'b0;
                nxt.pass_active          = 1'b0;
                st = ST_READY;
            end
            ACT_PASS: begin
                nxt.pass_active = 1'b0;
                if (cur.enumeration_finished) begin
                    st = ST_DONE;
                end else if (!item.presence) begin
                    nxt.enumeration_finished = 1'b1;
                    st = ST_DONE;
                end else begin
                    nxt.pass_active      = 1'b1;
                    nxt.bit_position     = '0;
                    nxt.last_zero_branch = POS_NONE;
                    nxt.running_crc      = '0;
                    dir = pick_dir('0, cur.last_discrepancy, cur.rom_store);
                    st  = ST_CONTINUE;
                end
            end
            ACT_TRIPLET: begin
                if (!cur.pass_active) begin
                    st = ST_ERROR;
                end else if (item.link_error) begin
                    nxt.pass_active = 1'b0;
                    st = ST_ERROR;
                end else if (item.first_bit && item.complement_bit) begin
                    nxt.enumeration_finished = 1'b1;
                    nxt.pass_active          = 1'b0;
                    st = ST_DONE;
                end else begin
                    nxt.rom_store        = rom_upd;
                    nxt.running_crc      = crc_upd;
                    nxt.bit_position     = pos_upd;
                    nxt.last_zero_branch = lzb_upd;
                    if (pos_upd < POS_W'(ROM_BITS)) begin
                        dir = pick_dir(pos_upd, cur.last_discrepancy, rom_upd);
                        st  = ST_CONTINUE;
                    end else begin
                        nxt.pass_active = 1'b0;
                        if (crc_upd != '0 || rom_upd[7:0] == 8'h00) begin
                            st = ST_ERROR;
                        end else begin
                            nxt.last_discrepancy     = lzb_upd;
                            nxt.enumeration_finished = (lzb_upd == POS_NONE);
                            st = ST_FOUND;
                        end
                    end
                end
            end
            default: begin
                st = ST_ERROR;
            end
        endcase
        res.next_direction = dir;
        res.status         = st;
        res.serial_number  = nxt.rom_store;
        res.last_device    = nxt.enumeration_finished;
    end

endmodule

// ----- rtl/ors_out_buf.sv -----
`timescale 1ns / 1ps

module ors_out_buf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic [ors_pkg::OUT_W-1:0] push_data,
    output logic                      push_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ors_pkg::OUT_W-1:0] m_tdata
);
    import ors_pkg::*;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             pop;

    assign pop        = out_valid_reg && m_tready;
    assign push_ready = !skid_valid_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    // control: output stage plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                if (push) begin
                    skid_data_reg <= push_data;
                end
            end else if (push) begin
                out_data_reg <= push_data;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

// ----- rtl/onewire_rom_search_triplet.sv -----
`timescale 1ns / 1ps
// each accepted input's result is registered into the output buffer
// throughput: one item per cycle while s_tready is high; the search state updates at
// the input transfer. a result waiting on m_tready stays in the output register, the next
// in a one-entry skid, so s_tready drops only when two results are queued
// reset (aresetn low, synchronous) clears the search state and empties the output

module onewire_rom_search_triplet (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // action[1:0], presence, first_bit, complement_bit, taken_direction, link_error, pad
    input  logic [ors_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // next_direction, status[3:1], serial_number[67:4], last_device, pad
    output logic [ors_pkg::OUT_W-1:0] m_tdata
);
    import ors_pkg::*;

    search_state_t state_reg;
    search_state_t state_next;
    item_t         item;
    result_t       res;
    logic          accept;
    logic          buf_ready;

    assign s_tready = buf_ready;
    assign accept   = s_tvalid && buf_ready;

    // unpack the input transfer
    always_comb begin
        item.action          = s_tdata[1:0];
        item.presence        = s_tdata[2];
        item.first_bit       = s_tdata[3];
        item.complement_bit  = s_tdata[4];
        item.taken_direction = s_tdata[5];
        item.link_error      = s_tdata[6];
    end

    ors_step u_step (
        .item (item),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res)
    );

    // search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.rom_store            <= '0;
            state_reg.last_discrepancy     <= POS_NONE;
            state_reg.last_zero_branch     <= POS_NONE;
            state_reg.bit_position         <= '0;
            state_reg.enumeration_finished <= 1'b0;
            state_reg.pass_active          <= 1'b0;
            state_reg.running_crc          <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    ors_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_data  ({3'b000, res.last_device, res.serial_number, res.status,
                      res.next_direction}),
        .push_ready (buf_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- rtl/ors_checker.sv -----
`timescale 1ns / 1ps

module ors_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ors_pkg::OUT_W-1:0] m_tdata
);
    import ors_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every input transfer leaves a result waiting on the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transfer without a result");

    // a direction is given only with continue
    a_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] != ST_CONTINUE |-> !m_tdata[0])
        else $error("direction set outside continue");

    // a found rom has a nonzero family byte
    a_family: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] == ST_FOUND |-> m_tdata[11:4] != 8'h00)
        else $error("found with zero family byte");

    // a start result always reports more devices to come
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:1] == ST_READY |-> !m_tdata[68])
        else $error("ready with last device set");

endmodule

bind onewire_rom_search_triplet ors_checker u_ors_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
